FILE: hw/rtl/ifs_chaos_game_point_step_assert.svh
// Assertion macros shared by the RTL of the chaos-game point step.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef IFS_CHAOS_GAME_POINT_STEP_ASSERT_SVH
`define IFS_CHAOS_GAME_POINT_STEP_ASSERT_SVH

// Antecedent implies consequent in the same cycle.
`define ICG_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("same-cycle implication failed");

// Antecedent implies consequent in the next cycle.
`define ICG_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

`endif

FILE: hw/rtl/ifs_cg_pkg.sv
// Package of the chaos-game point step: types, codes and the map coefficients.
// The coefficients are derived at elaboration; no other dependencies.
`default_nettype none

package ifs_cg_pkg;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAC,
    ST_DIV,
    ST_OUT
  } state_e;

  typedef enum logic [1:0] {
    MAP_FIRST,
    MAP_SECOND,
    MAP_THIRD
  } map_sel_e;

  typedef enum logic [2:0] {
    REG_FIRST_LIMIT,
    REG_SECOND_LIMIT,
    REG_X_SCALE,
    REG_Y_SCALE,
    REG_SCREEN_WIDTH,
    REG_SCREEN_HEIGHT
  } reg_idx_e;

  localparam int unsigned DefaultMaxScreenDim = 1024;
  localparam int unsigned NumW = 56;

  typedef struct packed {
    logic signed [31:0] a;
    logic signed [31:0] b;
    logic signed [31:0] e;
    logic signed [31:0] c;
    logic signed [31:0] d;
    logic signed [31:0] f;
  } map_t;

  typedef struct packed {
    logic               en;
    logic               clr;
    logic signed [31:0] a;
    logic signed [31:0] b;
  } mac_op_t;

  typedef struct packed {
    logic               start;
    logic [26:0]        k;
    logic signed [32:0] d;
  } div_req_t;

  typedef struct packed {
    logic               busy;
    logic               done;
    logic signed [41:0] q;
  } div_rsp_t;

  localparam longint One30 = longint'(1) << 30;
  localparam longint HalfSqrt2 = 759250125;

  function automatic longint rnd_sh(longint v, int k);
    longint h;
    h = longint'(1) << (k - 1);
    if (v >= 0) return (v + h) >>> k;
    return -((-v + h) >>> k);
  endfunction

  function automatic longint isqrt64(longint unsigned v);
    longint unsigned r;
    longint unsigned bitv;
    longint unsigned rem;
    r = 0;
    rem = v;
    bitv = longint'(1) << 62;
    for (int i = 0; i < 32; i++) begin
      if (rem >= r + bitv) begin
        rem = rem - (r + bitv);
        r = (r >> 1) + bitv;
      end else begin
        r = r >> 1;
      end
      bitv = bitv >> 2;
    end
    return longint'(r);
  endfunction

  function automatic longint kmul(longint v);
    return rnd_sh(v * HalfSqrt2, 30);
  endfunction

  localparam longint EOff = (94 * One30 + 50) / 100;
  localparam longint FOff = (2 * One30 + 50) / 100;

  function automatic map_t make_map(longint fc, longint fs, longint gc, longint gs,
                                    longint ty);
    map_t m;
    longint e1;
    longint f1;
    e1 = rnd_sh(One30 - fc, 1);
    f1 = rnd_sh(2 * ty - gs, 1);
    m.a = 32'(kmul(fc - gs));
    m.b = 32'(kmul(-fs - gc));
    m.e = 32'(kmul(e1 - f1) + EOff);
    m.c = 32'(kmul(fc + gs));
    m.d = 32'(kmul(-fs + gc));
    m.f = 32'(kmul(e1 + f1) + FOff);
    return m;
  endfunction

  localparam longint Ty4 = (4 * One30 + 12) / 25;
  localparam longint Ty1 = (One30 + 12) / 25;
  localparam longint S3 = isqrt64(longint'(3) << 60);
  localparam longint MQ4 = 4 * isqrt64(longint'(11426896) << 38);
  localparam longint DotQ = 1068 * S3 - 1310 * One30;
  localparam longint CrsQ = 1310 * S3 + 1068 * One30;
  localparam longint MFc = (8842 * One30 + 5213) / 10426;
  localparam longint MFs = -((400 * One30 + 5213) / 10426);
  localparam longint LFc = (2640 * One30 + 5213) / 10426;
  localparam longint LFs = (4142 * One30 + 5213) / 10426;
  localparam longint TFc = (DotQ + 5213) / 10426;
  localparam longint TFs = (CrsQ + 5213) / 10426;
  localparam longint TGc = (DotQ * 524288 + MQ4 / 2) / MQ4;
  localparam longint TGs = (CrsQ * 524288 + MQ4 / 2) / MQ4;

  localparam map_t MapFirst = make_map(MFc, MFs, MFc, MFs, Ty4);
  localparam map_t MapSecond = make_map(LFc, LFs, LFc, LFs, Ty4);
  localparam map_t MapThird = make_map(TFc, TFs, TGc, TGs, Ty1);

  localparam logic signed [31:0] Q25 = 32'(((longint'(25) << 28) + 50) / 100);
  localparam logic signed [31:0] Q26 = 32'(((longint'(26) << 28) + 50) / 100);
  localparam logic signed [32:0] Q50 = 33'(((longint'(50) << 28) + 50) / 100);
  localparam logic signed [32:0] Q30 = 33'(((longint'(30) << 28) + 50) / 100);
  localparam logic [26:0] K11 = 27'(((longint'(11) << 28) + 50) / 100);
  localparam logic [26:0] K41 = 27'(((longint'(41) << 28) + 50) / 100);
  localparam logic [26:0] K40 = 27'(((longint'(40) << 28) + 50) / 100);
  localparam logic signed [31:0] OneQ28 = 32'(longint'(1) << 28);

  function automatic logic signed [65:0] rsh66(logic signed [65:0] v, int unsigned k);
    logic signed [65:0] h;
    h = 66'sd1 <<< (k - 1);
    if (!v[65]) return (v + h) >>> k;
    return -((-v + h) >>> k);
  endfunction

  function automatic logic signed [31:0] rsat30(logic signed [65:0] v);
    logic signed [65:0] r;
    r = rsh66(v, 30);
    if (r > 66'sd2147483647) return 32'sh7fffffff;
    if (r < -66'sd2147483648) return 32'sh80000000;
    return r[31:0];
  endfunction

  function automatic logic [7:0] level8(logic signed [42:0] v);
    logic signed [65:0] t;
    logic signed [65:0] r;
    t = (66'(v) <<< 8) - 66'(v);
    r = rsh66(t, 28);
    if (r[65]) return 8'd0;
    if (r > 66'sd255) return 8'd255;
    return r[7:0];
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/ifs_cg_mac.sv
// Shared signed 32x32 multiply-accumulate unit of the chaos-game point step.
// Product register, then accumulator; uses ifs_cg_pkg.
`default_nettype none

module ifs_cg_mac (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  ifs_cg_pkg::mac_op_t    op_i,
  output logic signed [65:0]     acc_o
);
  import ifs_cg_pkg::*;

  logic signed [63:0] prod_q, prod_d;
  logic               en_q, clr_q;
  logic signed [65:0] acc_q, acc_d;

  always_comb begin
    prod_d = op_i.a * op_i.b;
    acc_d = acc_q;
    if (en_q) begin
      acc_d = (clr_q ? 66'sd0 : acc_q) + 66'(prod_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q <= 1'b0;
      clr_q <= 1'b0;
    end else begin
      en_q <= op_i.en;
      clr_q <= op_i.clr;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    acc_q <= acc_d;
  end

  assign acc_o = acc_q;

endmodule

`default_nettype wire

FILE: hw/rtl/ifs_cg_div.sv
// Bit-serial restoring divider for the saturating reciprocals, one bit a cycle.
// Rounds half away from zero and clamps to plus or minus 2^40; uses ifs_cg_pkg.
`default_nettype none

module ifs_cg_div (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  ifs_cg_pkg::div_req_t  req_i,
  output ifs_cg_pkg::div_rsp_t  rsp_o
);
  import ifs_cg_pkg::*;

  localparam int unsigned CntW = $clog2(NumW);

  logic              busy_q, busy_d, done_q, done_d, neg_q, neg_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [NumW-1:0]   nq_q, nq_d;
  logic [32:0]       ud_q, ud_d, rem_q, rem_d;
  logic [33:0]       trial;
  logic [32:0]       ud_in;
  logic [40:0]       qclamp;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d = cnt_q;
    nq_d = nq_q;
    ud_d = ud_q;
    rem_d = rem_q;
    neg_d = neg_q;
    ud_in = req_i.d[32] ? 33'(-req_i.d) : 33'(req_i.d);
    trial = {rem_q, nq_q[NumW-1]};
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d = '0;
      ud_d = ud_in;
      rem_d = '0;
      neg_d = req_i.d[32];
      nq_d = {1'b0, req_i.k, 28'd0} + NumW'(ud_in >> 1);
    end else if (busy_q) begin
      if (trial >= {1'b0, ud_q}) begin
        rem_d = 33'(trial - {1'b0, ud_q});
        nq_d = {nq_q[NumW-2:0], 1'b1};
      end else begin
        rem_d = trial[32:0];
        nq_d = {nq_q[NumW-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntW'(NumW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_d;
    nq_q <= nq_d;
    ud_q <= ud_d;
    rem_q <= rem_d;
    neg_q <= neg_d;
  end

  assign qclamp = (nq_q > NumW'(64'd1 << 40)) ? 41'(64'd1 << 40) : nq_q[40:0];
  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.q = neg_q ? -$signed({1'b0, qclamp}) : $signed({1'b0, qclamp});

endmodule

`default_nettype wire

FILE: hw/rtl/ifs_chaos_game_point_step.sv
// Chaos-game point step: one item takes 13 steps of the multiply-accumulate state
// on the shared multiplier, then four reciprocal divisions, then the output state;
// a new item is accepted only when idle, once the last result is registered.
// Throughput is set by the bit-serial divider, one quotient bit a cycle.
// Reset (asynchronous, active low) clears the point to zero, restores the register
// defaults and leaves the block idle with no result pending.
`default_nettype none

module ifs_chaos_game_point_step #(
  parameter int unsigned MAX_SCREEN_DIM = ifs_cg_pkg::DefaultMaxScreenDim
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [15:0] random_fraction_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [9:0]  pixel_column_o,
  output logic [9:0]  pixel_row_o,
  output logic        on_screen_o,
  output logic [7:0]  red_level_o,
  output logic [7:0]  green_level_o,
  output logic [7:0]  blue_level_o
);
  import ifs_cg_pkg::*;

  localparam logic [3:0] SpAx = 4'd0, SpBy = 4'd1, SpE = 4'd2, SpCx = 4'd3,
                         SpDy = 4'd4, SpF = 4'd5, SpPx = 4'd6, SpNy = 4'd7,
                         SpPy = 4'd8, SpRy = 4'd9, SpGx = 4'd10, SpRed = 4'd11,
                         SpGrn = 4'd12;
  localparam logic [31:0] MaxDim = 32'(MAX_SCREEN_DIM);

  state_e             state_q, state_d;
  map_sel_e           map_q, map_d;
  logic [3:0]         step_q, step_d;
  logic [1:0]         didx_q, didx_d;
  logic               drun_q, drun_d;
  logic [15:0]        lim0_q, lim1_q, xs_q, ys_q;
  logic [10:0]        sw_q, sh_q;
  logic signed [31:0] ptx_q, ptx_d, pty_q, pty_d, nx_q, nx_d, ny_q, ny_d;
  logic [9:0]         col_q, col_d, row_q, row_d;
  logic               onx_q, onx_d, ony_q, ony_d;
  logic signed [42:0] red_q, red_d, grn_q, grn_d, blu_q, blu_d;
  logic               ov_q, ov_d;
  logic [9:0]         ocol_q, ocol_d, orow_q, orow_d;
  logic               oon_q, oon_d;
  logic [7:0]         ored_q, ored_d, ogrn_q, ogrn_d, oblu_q, oblu_d;
  map_t               coef;
  mac_op_t            mop;
  div_req_t           dreq;
  div_rsp_t           drsp;
  logic signed [65:0] acc;
  logic signed [65:0] qacc;
  logic [31:0]        limw, limh;
  logic               both_on;

  ifs_cg_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .op_i   (mop),
    .acc_o  (acc)
  );

  ifs_cg_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (dreq),
    .rsp_o  (drsp)
  );

  assign limw = ({21'd0, sw_q} < MaxDim) ? {21'd0, sw_q} : MaxDim;
  assign limh = ({21'd0, sh_q} < MaxDim) ? {21'd0, sh_q} : MaxDim;
  assign qacc = rsh66(acc, 28);
  assign both_on = onx_q && ony_q;

  always_comb begin
    case (map_q)
      MAP_FIRST:  coef = MapFirst;
      MAP_SECOND: coef = MapSecond;
      default:    coef = MapThird;
    endcase
  end

  always_comb begin
    state_d = state_q;
    map_d = map_q;
    step_d = step_q;
    didx_d = didx_q;
    drun_d = drun_q;
    ptx_d = ptx_q;
    pty_d = pty_q;
    nx_d = nx_q;
    ny_d = ny_q;
    col_d = col_q;
    row_d = row_q;
    onx_d = onx_q;
    ony_d = ony_q;
    red_d = red_q;
    grn_d = grn_q;
    blu_d = blu_q;
    ov_d = ov_q && !out_ready_i;
    ocol_d = ocol_q;
    orow_d = orow_q;
    oon_d = oon_q;
    ored_d = ored_q;
    ogrn_d = ogrn_q;
    oblu_d = oblu_q;
    mop = '0;
    dreq = '0;
    in_ready_o = (state_q == ST_IDLE);
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (random_fraction_i < lim0_q) begin
            map_d = MAP_FIRST;
          end else if (random_fraction_i < lim1_q) begin
            map_d = MAP_SECOND;
          end else begin
            map_d = MAP_THIRD;
          end
          step_d = SpAx;
          state_d = ST_MAC;
        end
      end
      ST_MAC: begin
        step_d = step_q + 4'd1;
        case (step_q)
          SpAx: mop = '{en: 1'b1, clr: 1'b1, a: coef.a, b: ptx_q};
          SpBy: mop = '{en: 1'b1, clr: 1'b0, a: coef.b, b: pty_q};
          SpE:  mop = '{en: 1'b1, clr: 1'b0, a: coef.e, b: OneQ28};
          SpCx: mop = '{en: 1'b1, clr: 1'b1, a: coef.c, b: ptx_q};
          SpDy: begin
            mop = '{en: 1'b1, clr: 1'b0, a: coef.d, b: pty_q};
            nx_d = rsat30(acc);
          end
          SpF:  mop = '{en: 1'b1, clr: 1'b0, a: coef.f, b: OneQ28};
          SpPx: mop = '{en: 1'b1, clr: 1'b1, a: nx_q, b: {16'd0, xs_q}};
          SpNy: ny_d = rsat30(acc);
          SpPy: begin
            mop = '{en: 1'b1, clr: 1'b1, a: ny_q, b: {16'd0, ys_q}};
            onx_d = !acc[65] && (acc[65:34] < limw);
            col_d = acc[43:34];
          end
          SpRy: mop = '{en: 1'b1, clr: 1'b1, a: Q25, b: ny_q};
          SpGx: begin
            mop = '{en: 1'b1, clr: 1'b1, a: Q26, b: nx_q};
            ony_d = !acc[65] && (acc[65:34] < limh);
            row_d = acc[43:34];
          end
          SpRed: red_d = qacc[42:0];
          SpGrn: begin
            grn_d = qacc[42:0];
            blu_d = '0;
            didx_d = '0;
            drun_d = 1'b0;
            state_d = ST_DIV;
          end
          default: state_d = ST_DIV;
        endcase
      end
      ST_DIV: begin
        if (!drun_q) begin
          drun_d = 1'b1;
          dreq.start = 1'b1;
          case (didx_q)
            2'd0: begin
              dreq.k = K11;
              dreq.d = 33'(nx_q) + Q50;
            end
            2'd1: begin
              dreq.k = K41;
              dreq.d = 33'(ny_q);
            end
            2'd2: begin
              dreq.k = K40;
              dreq.d = 33'(ny_q) + Q30;
            end
            default: begin
              dreq.k = K11;
              dreq.d = 33'(nx_q) + Q30;
            end
          endcase
        end else if (drsp.done) begin
          drun_d = 1'b0;
          didx_d = didx_q + 2'd1;
          case (didx_q)
            2'd0:    red_d = red_q + 43'(drsp.q);
            2'd1:    grn_d = grn_q + 43'(drsp.q);
            default: blu_d = blu_q + 43'(drsp.q);
          endcase
          if (didx_q == 2'd3) begin
            state_d = ST_OUT;
          end
        end
      end
      ST_OUT: begin
        if (!ov_q || out_ready_i) begin
          ov_d = 1'b1;
          ocol_d = both_on ? col_q : 10'd0;
          orow_d = both_on ? row_q : 10'd0;
          oon_d = both_on;
          ored_d = level8(red_q);
          ogrn_d = level8(grn_q);
          oblu_d = level8(blu_q);
          ptx_d = nx_q;
          pty_d = ny_q;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q <= SpAx;
      didx_q <= '0;
      drun_q <= 1'b0;
      ov_q <= 1'b0;
      ptx_q <= '0;
      pty_q <= '0;
      lim0_q <= 16'd49152;
      lim1_q <= 16'd62259;
      xs_q <= 16'd31511;
      ys_q <= 16'd22917;
      sw_q <= 11'd746;
      sh_q <= 11'd746;
    end else begin
      state_q <= state_d;
      step_q <= step_d;
      didx_q <= didx_d;
      drun_q <= drun_d;
      ov_q <= ov_d;
      ptx_q <= ptx_d;
      pty_q <= pty_d;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          REG_FIRST_LIMIT:   lim0_q <= cfg_data_i;
          REG_SECOND_LIMIT:  lim1_q <= cfg_data_i;
          REG_X_SCALE:       xs_q <= cfg_data_i;
          REG_Y_SCALE:       ys_q <= cfg_data_i;
          REG_SCREEN_WIDTH:  sw_q <= cfg_data_i[10:0];
          REG_SCREEN_HEIGHT: sh_q <= cfg_data_i[10:0];
          default:           ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    map_q <= map_d;
    nx_q <= nx_d;
    ny_q <= ny_d;
    col_q <= col_d;
    row_q <= row_d;
    onx_q <= onx_d;
    ony_q <= ony_d;
    red_q <= red_d;
    grn_q <= grn_d;
    blu_q <= blu_d;
    ocol_q <= ocol_d;
    orow_q <= orow_d;
    oon_q <= oon_d;
    ored_q <= ored_d;
    ogrn_q <= ogrn_d;
    oblu_q <= oblu_d;
  end

  assign cfg_ready_o = 1'b1;
  assign out_valid_o = ov_q;
  assign pixel_column_o = ocol_q;
  assign pixel_row_o = orow_q;
  assign on_screen_o = oon_q;
  assign red_level_o = ored_q;
  assign green_level_o = ogrn_q;
  assign blue_level_o = oblu_q;

`include "ifs_chaos_game_point_step_assert.svh"

  `ICG_ASSERT_NEXT(a_busy_after_accept, in_valid_i && in_ready_o, !in_ready_o)
  `ICG_ASSERT_NOW(a_div_idle_when_ready, in_ready_o, !drsp.busy)
  `ICG_ASSERT_NOW(a_off_screen_zero, out_valid_o && !on_screen_o,
                  pixel_column_o == 10'd0 && pixel_row_o == 10'd0)

endmodule

`default_nettype wire
